FILE: rtl/core/ppd_pkg.sv
// Package for the preemptive priority dispatcher: widths, request codes,
// and the command and status bundles between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
package ppd_pkg;

	localparam int REQ_W  = 3;
	localparam int ID_W   = 8;
	localparam int PRIO_W = 3;
	localparam int ENT_W  = ID_W + PRIO_W;

	localparam logic [REQ_W-1:0] REQ_ENQ   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_DONE  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_START = 3'd2;
	localparam logic [REQ_W-1:0] REQ_STOP  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd4;

	typedef struct packed {
		logic id_load;    // capture the incoming beat
		logic exec;       // apply the request to the flags and counts
		logic ins_rd;     // one step of the sorted insert, read side
		logic ins_cmp;    // one step of the sorted insert, compare and move
		logic push_cur;   // push the running task onto the stack
		logic push_new;   // push the new task onto the stack
		logic disp_rd;    // read the stack top and the pool head
		logic disp_apply; // take one of them as the new running task
		logic out_load;   // move the result into the output register
	} cmd_t;

	typedef struct packed {
		logic enq_pool;
		logic enq_push;
		logic ins_j_zero;
		logic ins_stop;
		logic disp_needed;
		logic out_free;
	} stat_t;

endpackage

FILE: rtl/core/ppd_ram.sv
// Generic single write, single read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
module ppd_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/core/ppd_ctrl.sv
// Controller state machine of the dispatcher: sequences one request
// through execute, insert or push, dispatch and output. Uses ppd_pkg.
`timescale 1ns / 1ps
module ppd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ppd_pkg::stat_t stat,
	output ppd_pkg::cmd_t  cmd
);
	import ppd_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_EXEC  = 4'd1;
	localparam logic [3:0] ST_INSRD = 4'd2;
	localparam logic [3:0] ST_INSCM = 4'd3;
	localparam logic [3:0] ST_PUSH1 = 4'd4;
	localparam logic [3:0] ST_PUSH2 = 4'd5;
	localparam logic [3:0] ST_DCHK  = 4'd6;
	localparam logic [3:0] ST_DAPP  = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;

	logic [3:0] state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.id_load = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (stat.enq_pool) state_d = ST_INSRD;
				else if (stat.enq_push) state_d = ST_PUSH1;
				else state_d = ST_DCHK;
			end
			ST_INSRD: begin
				cmd.ins_rd = 1'b1;
				state_d    = stat.ins_j_zero ? ST_DCHK : ST_INSCM;
			end
			ST_INSCM: begin
				cmd.ins_cmp = 1'b1;
				state_d     = stat.ins_stop ? ST_DCHK : ST_INSRD;
			end
			ST_PUSH1: begin
				cmd.push_cur = 1'b1;
				state_d      = ST_PUSH2;
			end
			ST_PUSH2: begin
				cmd.push_new = 1'b1;
				state_d      = ST_DCHK;
			end
			ST_DCHK: begin
				if (stat.disp_needed) begin
					cmd.disp_rd = 1'b1;
					state_d     = ST_DAPP;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_DAPP: begin
				cmd.disp_apply = 1'b1;
				state_d        = ST_OUT;
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

FILE: rtl/core/ppd_datapath.sv
// Datapath of the dispatcher: flags, running task, ring-buffered sorted
// pool and preemption stack in RAM, result and output registers.
// Uses ppd_pkg and ppd_ram.
`timescale 1ns / 1ps
module ppd_datapath #(
	parameter int POOL_DEPTH      = 16,
	parameter int STACK_DEPTH     = 16,
	parameter int TASK_ID_BITS    = 8,
	parameter int PRIORITY_LEVELS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ppd_pkg::cmd_t              cmd,
	output ppd_pkg::stat_t             stat,
	input  logic [ppd_pkg::REQ_W-1:0]  req_type,
	input  logic [ppd_pkg::ID_W-1:0]   task_id,
	input  logic [ppd_pkg::PRIO_W-1:0] priority_req,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       dispatch_valid,
	output logic [ppd_pkg::ID_W-1:0]   dispatch_task,
	output logic [ppd_pkg::PRIO_W-1:0] dispatch_priority,
	output logic                       interrupt_current,
	output logic                       finished_valid,
	output logic [ppd_pkg::ID_W-1:0]   finished_task,
	output logic                       finished_interrupted,
	output logic                       overflow,
	output logic                       is_running,
	output logic                       is_idle
);
	import ppd_pkg::*;

	localparam int PPW = $clog2(POOL_DEPTH);
	localparam int PCW = $clog2(POOL_DEPTH + 1);
	localparam int SPW = $clog2(STACK_DEPTH);
	localparam int SCW = $clog2(STACK_DEPTH + 1);
	localparam logic [ID_W-1:0] ID_MASK =
		(TASK_ID_BITS >= ID_W) ? {ID_W{1'b1}} : ID_W'((1 << TASK_ID_BITS) - 1);
	localparam logic [PRIO_W-1:0] PRIO_MAX = PRIO_W'(PRIORITY_LEVELS - 1);

	// Request registers.
	logic [REQ_W-1:0]  req_q;
	logic [ID_W-1:0]   id_q;
	logic [PRIO_W-1:0] pr_q;
	logic [PRIO_W-1:0] pr_sat;

	// Scheduler state.
	logic              running_q, idle_q, active_q, cur_intr_q;
	logic [ID_W-1:0]   cur_id_q;
	logic [PRIO_W-1:0] cur_pr_q;
	logic [PPW-1:0]    head_q;
	logic [PCW-1:0]    pcount_q, j_q;
	logic [SCW-1:0]    scount_q;

	// Result being built and the output register.
	logic              r_dv_q, r_intr_q, r_fv_q, r_fi_q, r_ovf_q;
	logic [ID_W-1:0]   r_dt_q, r_ft_q;
	logic [PRIO_W-1:0] r_dp_q;
	logic              ov_q;

	// RAM ports.
	logic             p_we, s_we;
	logic [PPW-1:0]   p_waddr, p_raddr;
	logic [SPW-1:0]   s_waddr, s_raddr;
	logic [ENT_W-1:0] p_wdata, s_wdata, p_rdata, s_rdata;

	logic preempt, pool_full, stack_short;
	logic [PPW-1:0] phys_j, phys_jm1, phys_one;

	function automatic logic [PPW-1:0] wrap(input logic [PPW-1:0] h,
		input logic [PCW-1:0] rel);
		logic [PPW:0] sum;
		sum = (PPW+1)'(h) + (PPW+1)'(rel);
		if (sum >= (PPW+1)'(POOL_DEPTH)) sum = sum - (PPW+1)'(POOL_DEPTH);
		return sum[PPW-1:0];
	endfunction

	assign pr_sat = ({4'b0, priority_req} > 7'(PRIORITY_LEVELS - 1)) ? PRIO_MAX
		: priority_req;

	assign preempt     = running_q && !idle_q && (pr_q > cur_pr_q);
	assign pool_full   = (pcount_q >= PCW'(POOL_DEPTH));
	assign stack_short = ((SCW+1)'(scount_q) + (SCW+1)'(2)) > (SCW+1)'(STACK_DEPTH);

	assign phys_j   = wrap(head_q, j_q);
	assign phys_jm1 = wrap(head_q, j_q - PCW'(1));
	assign phys_one = wrap(head_q, PCW'(1));

	assign stat.enq_pool    = (req_q == REQ_ENQ) && !preempt && !pool_full;
	assign stat.enq_push    = (req_q == REQ_ENQ) && preempt && !stack_short;
	assign stat.ins_j_zero  = (j_q == '0);
	assign stat.ins_stop    = (p_rdata[PRIO_W-1:0] >= pr_q);
	assign stat.disp_needed = running_q && idle_q && (scount_q != '0 || pcount_q != '0);
	assign stat.out_free    = !ov_q || out_ready;

	// Pool RAM control.
	always_comb begin
		p_we    = 1'b0;
		p_waddr = phys_j;
		p_wdata = {id_q, pr_q};
		p_raddr = cmd.disp_rd ? head_q : phys_jm1;
		if (cmd.ins_rd && j_q == '0) begin
			p_we = 1'b1;
		end
		if (cmd.ins_cmp) begin
			p_we = 1'b1;
			if (!stat.ins_stop) p_wdata = p_rdata;
		end
	end

	// Stack RAM control.
	always_comb begin
		s_we    = cmd.push_cur || cmd.push_new;
		s_waddr = scount_q[SPW-1:0];
		s_wdata = cmd.push_cur ? {cur_id_q, cur_pr_q} : {id_q, pr_q};
		s_raddr = SPW'(scount_q - SCW'(1));
	end

	ppd_ram #(.WIDTH(ENT_W), .DEPTH(POOL_DEPTH)) u_pool (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata)
	);

	ppd_ram #(.WIDTH(ENT_W), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.id_load) begin
			req_q <= req_type;
			id_q  <= task_id & ID_MASK;
			pr_q  <= pr_sat;
		end
	end

	// Scheduler state and result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q  <= 1'b0;
			idle_q     <= 1'b0;
			active_q   <= 1'b0;
			cur_intr_q <= 1'b0;
			cur_id_q   <= '0;
			cur_pr_q   <= '0;
			head_q     <= '0;
			pcount_q   <= '0;
			scount_q   <= '0;
			j_q        <= '0;
			r_dv_q     <= 1'b0;
			r_intr_q   <= 1'b0;
			r_fv_q     <= 1'b0;
			r_fi_q     <= 1'b0;
			r_ovf_q    <= 1'b0;
			r_dt_q     <= '0;
			r_ft_q     <= '0;
			r_dp_q     <= '0;
		end else begin
			if (cmd.id_load) begin
				r_dv_q   <= 1'b0;
				r_intr_q <= 1'b0;
				r_fv_q   <= 1'b0;
				r_fi_q   <= 1'b0;
				r_ovf_q  <= 1'b0;
				r_dt_q   <= '0;
				r_ft_q   <= '0;
				r_dp_q   <= '0;
			end
			if (cmd.exec) begin
				j_q <= pcount_q;
				priority case (req_q)
					REQ_ENQ: begin
						if (preempt) begin
							if (stack_short) begin
								r_ovf_q <= 1'b1;
							end else begin
								cur_intr_q <= 1'b1;
								r_intr_q   <= 1'b1;
							end
						end else if (pool_full) begin
							r_ovf_q <= 1'b1;
						end
					end
					REQ_DONE: begin
						if (active_q) begin
							r_fv_q     <= 1'b1;
							r_ft_q     <= cur_id_q;
							r_fi_q     <= cur_intr_q;
							cur_intr_q <= 1'b0;
							active_q   <= 1'b0;
							idle_q     <= 1'b1;
						end
					end
					REQ_START: begin
						if (!running_q) begin
							running_q <= 1'b1;
							idle_q    <= !active_q;
						end
					end
					REQ_STOP: begin
						if (running_q) begin
							running_q <= 1'b0;
							if (idle_q) begin
								idle_q <= 1'b0;
							end else begin
								cur_intr_q <= 1'b1;
								r_intr_q   <= 1'b1;
							end
						end
					end
					REQ_CLEAR: begin
						pcount_q <= '0;
						scount_q <= '0;
					end
					default: ;
				endcase
			end
			if (cmd.ins_rd && j_q == '0) begin
				pcount_q <= pcount_q + PCW'(1);
			end
			if (cmd.ins_cmp) begin
				if (stat.ins_stop) pcount_q <= pcount_q + PCW'(1);
				else j_q <= j_q - PCW'(1);
			end
			if (cmd.push_cur || cmd.push_new) begin
				scount_q <= scount_q + SCW'(1);
			end
			if (cmd.disp_apply) begin
				if (scount_q != '0 && (pcount_q == '0
						|| s_rdata[PRIO_W-1:0] >= p_rdata[PRIO_W-1:0])) begin
					scount_q <= scount_q - SCW'(1);
					cur_id_q <= s_rdata[ENT_W-1:PRIO_W];
					cur_pr_q <= s_rdata[PRIO_W-1:0];
					r_dt_q   <= s_rdata[ENT_W-1:PRIO_W];
					r_dp_q   <= s_rdata[PRIO_W-1:0];
				end else begin
					head_q   <= phys_one;
					pcount_q <= pcount_q - PCW'(1);
					cur_id_q <= p_rdata[ENT_W-1:PRIO_W];
					cur_pr_q <= p_rdata[PRIO_W-1:0];
					r_dt_q   <= p_rdata[ENT_W-1:PRIO_W];
					r_dp_q   <= p_rdata[PRIO_W-1:0];
				end
				cur_intr_q <= 1'b0;
				active_q   <= 1'b1;
				idle_q     <= 1'b0;
				r_dv_q     <= 1'b1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.out_load) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			dispatch_valid       <= r_dv_q;
			dispatch_task        <= r_dt_q;
			dispatch_priority    <= r_dp_q;
			interrupt_current    <= r_intr_q;
			finished_valid       <= r_fv_q;
			finished_task        <= r_ft_q;
			finished_interrupted <= r_fi_q;
			overflow             <= r_ovf_q;
			is_running           <= running_q;
			is_idle              <= idle_q;
		end
	end

	assign out_valid = ov_q;
endmodule

FILE: rtl/core/preemptive_priority_dispatcher.sv
// Top level of the preemptive priority dispatcher.
// Joins the controller ppd_ctrl and the datapath ppd_datapath; uses ppd_pkg.
`timescale 1ns / 1ps
// One request beat goes in, one result beat comes out. The block handles a
// single request at a time. An accepted request passes the execute step,
// then, for an enqueue that fits, either the sorted pool insert or the stack
// pushes of the running task and the new one, then the dispatch check, and
// last the output step, which loads the result into the output register
// once it is free. A pool insert walks past each queued pool task of lower
// priority, or past every queued task when it lands at the head. The pool
// is a sorted ring in a RAM with one read and one write port, and each walk
// step reads one entry and writes it one place further on. A dispatch adds
// a step in which the stack top and the pool head read in the cycle before
// are compared and one is taken. A finished result waits in an output
// register, so the next request is taken while the previous result is still unclaimed.
// Both stores are RAMs whose contents are never read beyond their fill
// counts, so no clearing pass follows reset.
module preemptive_priority_dispatcher #(
	parameter int POOL_DEPTH      = 16,
	parameter int STACK_DEPTH     = 16,
	parameter int TASK_ID_BITS    = 8,
	parameter int PRIORITY_LEVELS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [ppd_pkg::REQ_W-1:0]  req_type,
	input  logic [ppd_pkg::ID_W-1:0]   task_id,
	input  logic [ppd_pkg::PRIO_W-1:0] priority_req,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       dispatch_valid,
	output logic [ppd_pkg::ID_W-1:0]   dispatch_task,
	output logic [ppd_pkg::PRIO_W-1:0] dispatch_priority,
	output logic                       interrupt_current,
	output logic                       finished_valid,
	output logic [ppd_pkg::ID_W-1:0]   finished_task,
	output logic                       finished_interrupted,
	output logic                       overflow,
	output logic                       is_running,
	output logic                       is_idle
);
	import ppd_pkg::*;

	// Commands from the controller and status back from the datapath.
	cmd_t  cmd;
	stat_t stat;

	// The controller only sequences; every decision it takes comes from in_valid
	// or the status bundle, which the datapath derives from its registers, its RAM read data and out_ready.
	ppd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.stat(stat), .cmd(cmd)
	);

	// The datapath holds the flags, the running task, both stores and the
	// output register that parts the result side from the request side.
	ppd_datapath #(
		.POOL_DEPTH(POOL_DEPTH), .STACK_DEPTH(STACK_DEPTH),
		.TASK_ID_BITS(TASK_ID_BITS), .PRIORITY_LEVELS(PRIORITY_LEVELS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.req_type(req_type), .task_id(task_id), .priority_req(priority_req),
		.out_valid(out_valid), .out_ready(out_ready),
		.dispatch_valid(dispatch_valid), .dispatch_task(dispatch_task),
		.dispatch_priority(dispatch_priority),
		.interrupt_current(interrupt_current),
		.finished_valid(finished_valid), .finished_task(finished_task),
		.finished_interrupted(finished_interrupted), .overflow(overflow),
		.is_running(is_running), .is_idle(is_idle)
	);
endmodule

FILE: bench/tb_preemptive_priority_dispatcher.sv
// Self-checking testbench for the preemptive priority dispatcher.
// Drives request beats from a directed table and then random traffic, and
// checks every result beat against a behavioural model; uses ppd_pkg.
`timescale 1ns / 1ps
module tb_preemptive_priority_dispatcher;
	import ppd_pkg::*;

	localparam int POOL_N  = 16;
	localparam int STACK_N = 16;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [REQ_W-1:0]  req;
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] pr;
	} req_beat_t;

	typedef struct packed {
		logic              d_valid;
		logic [ID_W-1:0]   d_task;
		logic [PRIO_W-1:0] d_prio;
		logic              intr;
		logic              f_valid;
		logic [ID_W-1:0]   f_task;
		logic              f_intr;
		logic              ovf;
		logic              running;
		logic              idle;
	} sched_result_t;

	// One row of the directed table: a request, and where chk is set, the
	// result as typed in by hand, compared on top of the model.
	typedef struct packed {
		req_beat_t     beat;
		logic          chk;
		sched_result_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [REQ_W-1:0] req_type = '0;
	logic [ID_W-1:0] task_id = '0;
	logic [PRIO_W-1:0] priority_req = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic dispatch_valid;
	logic [ID_W-1:0] dispatch_task;
	logic [PRIO_W-1:0] dispatch_priority;
	logic interrupt_current;
	logic finished_valid;
	logic [ID_W-1:0] finished_task;
	logic finished_interrupted;
	logic overflow;
	logic is_running;
	logic is_idle;

	preemptive_priority_dispatcher dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Model state of the scheduler.
	logic m_running, m_idle, m_intr_flag, m_active;
	logic [ID_W-1:0] m_cur_id;
	logic [PRIO_W-1:0] m_cur_prio;
	logic [ID_W-1:0] pool_id[POOL_N];
	logic [PRIO_W-1:0] pool_pr[POOL_N];
	logic [ID_W-1:0] stk_id[STACK_N];
	logic [PRIO_W-1:0] stk_pr[STACK_N];
	int pool_cnt, stk_cnt;

	sched_result_t expected_results[$];
	logic          hand_check[$];
	sched_result_t hand_value[$];
	int errors = 0;
	int idle_cycles = 0;
	int sent_count = 0;

	function automatic void reset_model();
		m_running = 0; m_idle = 0; m_intr_flag = 0; m_active = 0;
		m_cur_id = '0; m_cur_prio = '0;
		pool_cnt = 0; stk_cnt = 0;
	endfunction

	function automatic sched_result_t schedule(req_beat_t b);
		sched_result_t r;
		int pos;
		r = '0;
		case (b.req)
			REQ_ENQ: begin
				if (m_running && !m_idle && b.pr > m_cur_prio) begin
					if (stk_cnt + 2 > STACK_N) begin
						r.ovf = 1;
					end else begin
						m_intr_flag = 1;
						r.intr = 1;
						stk_id[stk_cnt] = m_cur_id; stk_pr[stk_cnt] = m_cur_prio;
						stk_id[stk_cnt+1] = b.id; stk_pr[stk_cnt+1] = b.pr;
						stk_cnt += 2;
					end
				end else if (pool_cnt >= POOL_N) begin
					r.ovf = 1;
				end else begin
					// Sorted insert, first-in first-out among equals.
					pos = 0;
					while (pos < pool_cnt && pool_pr[pos] >= b.pr) pos++;
					for (int k = pool_cnt; k > pos; k--) begin
						pool_id[k] = pool_id[k-1];
						pool_pr[k] = pool_pr[k-1];
					end
					pool_id[pos] = b.id; pool_pr[pos] = b.pr;
					pool_cnt++;
				end
			end
			REQ_DONE: begin
				if (m_active) begin
					r.f_valid = 1;
					r.f_task = m_cur_id;
					r.f_intr = m_intr_flag;
					m_intr_flag = 0; m_active = 0; m_idle = 1;
				end
			end
			REQ_START: begin
				if (!m_running) begin
					m_running = 1;
					m_idle = !m_active;
				end
			end
			REQ_STOP: begin
				if (m_running) begin
					m_running = 0;
					if (m_idle) begin
						m_idle = 0;
					end else begin
						m_intr_flag = 1;
						r.intr = 1;
					end
				end
			end
			REQ_CLEAR: begin
				pool_cnt = 0; stk_cnt = 0;
			end
			default: ;
		endcase
		if (m_running && m_idle && (stk_cnt > 0 || pool_cnt > 0)) begin
			if (stk_cnt > 0 && (pool_cnt == 0 || stk_pr[stk_cnt-1] >= pool_pr[0])) begin
				stk_cnt--;
				m_cur_id = stk_id[stk_cnt];
				m_cur_prio = stk_pr[stk_cnt];
			end else begin
				m_cur_id = pool_id[0];
				m_cur_prio = pool_pr[0];
				for (int k = 1; k < pool_cnt; k++) begin
					pool_id[k-1] = pool_id[k];
					pool_pr[k-1] = pool_pr[k];
				end
				pool_cnt--;
			end
			m_intr_flag = 0; m_active = 1; m_idle = 0;
			r.d_valid = 1; r.d_task = m_cur_id; r.d_prio = m_cur_prio;
		end
		r.running = m_running;
		r.idle = m_idle;
		return r;
	endfunction

	// Random gap: mostly none or short, now and then long.
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Sends one beat; the expectation is queued at acceptance. Valid is
	// dropped only at the start of a gap, so a beat that follows directly
	// keeps it high.
	task automatic send(req_beat_t b, logic chk, sched_result_t want);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= b.req;
		task_id <= b.id;
		priority_req <= b.pr;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_results.push_back(schedule(b));
		hand_check.push_back(chk);
		hand_value.push_back(want);
		sent_count++;
	endtask

	function automatic req_beat_t mk(logic [REQ_W-1:0] q, int id, int pr);
		req_beat_t b;
		b.req = q; b.id = id[ID_W-1:0]; b.pr = pr[PRIO_W-1:0];
		return b;
	endfunction

	// Result side: stalls at random and compares each beat field by field.
	task automatic compare_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready || out_valid && out_ready) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (out_valid && out_ready) begin
				sched_result_t e, got;
				got = '{dispatch_valid, dispatch_task, dispatch_priority,
					interrupt_current, finished_valid, finished_task,
					finished_interrupted, overflow, is_running, is_idle};
				if (expected_results.size() == 0) begin
					$error("result beat with no request outstanding");
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (hand_check.pop_front() && hand_value[0] != e) begin
						$error("directed row disagrees with model: expected %h, model %h",
							hand_value[0], e);
						errors++;
					end
					void'(hand_value.pop_front());
					compare_field("dispatch_valid", e.d_valid, got.d_valid);
					compare_field("dispatch_task", e.d_task, got.d_task);
					compare_field("dispatch_priority", e.d_prio, got.d_prio);
					compare_field("interrupt_current", e.intr, got.intr);
					compare_field("finished_valid", e.f_valid, got.f_valid);
					compare_field("finished_task", e.f_task, got.f_task);
					compare_field("finished_interrupted", e.f_intr, got.f_intr);
					compare_field("overflow", e.ovf, got.ovf);
					compare_field("is_running", e.running, got.running);
					compare_field("is_idle", e.idle, got.idle);
				end
			end
		end
	end

	// Receiver stall pattern: bursts of ready, gaps of random length.
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			g = gap_len();
			if (g > 0) begin
				out_ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	end

	// The watchdog ends the run when nothing moves for too long.
	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic sched_result_t res(logic dv, int dt, int dp, logic ir,
			logic fv, int ft, logic fi, logic ov, logic rn, logic id);
		sched_result_t r;
		r = '{dv, dt[ID_W-1:0], dp[PRIO_W-1:0], ir, fv, ft[ID_W-1:0], fi, ov, rn, id};
		return r;
	endfunction

	row_t table_rows[$];

	initial begin
		int kind, burst;
		reset_model();
		// Directed rows. Result typed in only where obvious.
		table_rows.push_back('{mk(REQ_DONE, 0, 0), 1, res(0,0,0,0,0,0,0,0,0,0)});
		table_rows.push_back('{mk(REQ_STOP, 0, 0), 1, res(0,0,0,0,0,0,0,0,0,0)});
		table_rows.push_back('{mk(3'd7, 255, 7), 1, res(0,0,0,0,0,0,0,0,0,0)});
		table_rows.push_back('{mk(3'd5, 0, 0), 1, res(0,0,0,0,0,0,0,0,0,0)});
		table_rows.push_back('{mk(REQ_ENQ, 8'hAA, 2), 0, '0});
		table_rows.push_back('{mk(REQ_ENQ, 8'h55, 5), 0, '0});
		table_rows.push_back('{mk(REQ_ENQ, 8'h11, 5), 0, '0});
		table_rows.push_back('{mk(REQ_ENQ, 0, 0), 0, '0});
		table_rows.push_back('{mk(REQ_START, 0, 0), 1, res(1,8'h55,5,0,0,0,0,0,1,0)});
		table_rows.push_back('{mk(REQ_START, 0, 0), 0, '0});
		table_rows.push_back('{mk(REQ_ENQ, 255, 7), 1, res(0,0,0,1,0,0,0,0,1,0)});
		table_rows.push_back('{mk(REQ_DONE, 0, 0), 1, res(1,255,7,0,1,8'h55,1,0,1,0)});
		table_rows.push_back('{mk(REQ_DONE, 0, 0), 0, '0});
		table_rows.push_back('{mk(REQ_STOP, 0, 0), 0, '0});
		table_rows.push_back('{mk(REQ_START, 0, 0), 0, '0});
		table_rows.push_back('{mk(REQ_DONE, 0, 0), 0, '0});
		table_rows.push_back('{mk(REQ_STOP, 0, 0), 0, '0});
		table_rows.push_back('{mk(REQ_CLEAR, 0, 0), 0, '0});
		for (int i = 0; i < 17; i++)
			table_rows.push_back('{mk(REQ_ENQ, i, i % 8), 0, '0});
		table_rows.push_back('{mk(REQ_CLEAR, 0, 0), 0, '0});
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (table_rows[i]) send(table_rows[i].beat, table_rows[i].chk, table_rows[i].want);
		// Random traffic: enqueues with done, start/stop, clear and unused request
		// codes mixed in, and now and then a burst of enqueues after a start.
		while (sent_count < 1000) begin
			kind = $urandom_range(0, 99);
			if (kind < 50) begin
				send(mk(REQ_ENQ, $urandom_range(0, 255), $urandom_range(0, 7)), 0, '0);
			end else if (kind < 75) begin
				send(mk(REQ_DONE, $urandom_range(0, 255), $urandom_range(0, 7)), 0, '0);
			end else if (kind < 84) begin
				send(mk(REQ_START, $urandom_range(0, 255), $urandom_range(0, 7)), 0, '0);
			end else if (kind < 90) begin
				send(mk(REQ_STOP, $urandom_range(0, 255), $urandom_range(0, 7)), 0, '0);
			end else if (kind < 93) begin
				send(mk(REQ_CLEAR, $urandom_range(0, 255), $urandom_range(0, 7)), 0, '0);
			end else if (kind < 96) begin
				send(mk(REQ_W'($urandom_range(5, 7)), $urandom_range(0, 255),
					$urandom_range(0, 7)), 0, '0);
			end else begin
				// Preemption storm to fill the stack.
				burst = $urandom_range(4, 12);
				send(mk(REQ_START, 0, 0), 0, '0);
				for (int j = 0; j < burst; j++)
					send(mk(REQ_ENQ, $urandom_range(0, 255), $urandom_range(0, 7)), 0, '0);
			end
		end
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
